>>> rtl/lspt_pkg.sv
// shared types and constants for the latency sample percentile tracker
package lspt_pkg;

    localparam int SAMPLE_DEPTH = 256;
    localparam int IDX_W        = $clog2(SAMPLE_DEPTH);
    localparam int FILL_W       = $clog2(SAMPLE_DEPTH + 1);
    localparam int DUR_W        = 32;
    localparam int CNT_W        = 32;
    localparam int SUM_W        = 48;
    localparam int FRAC_W       = 17;
    localparam int FRAC_SHIFT   = 16;
    localparam int PROD_W       = FRAC_W + IDX_W;

    localparam logic [FRAC_W-1:0] FRAC_ONE   = FRAC_W'(65536);
    localparam logic              REQ_RECORD = 1'b0;
    localparam logic              REQ_QUERY  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    // what one cell hands to its right neighbor
    typedef struct packed {
        logic [DUR_W-1:0] val;
        logic             gt;
    } link_t;

endpackage

>>> rtl/lspt_if.sv
// request and response channel interfaces
interface lspt_req_if;
    import lspt_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [DUR_W-1:0]  sample_duration;
    logic [FRAC_W-1:0] quantile_fraction;

    modport source (output valid, req_type, sample_duration, quantile_fraction, input ready);
    modport sink   (input valid, req_type, sample_duration, quantile_fraction, output ready);
endinterface

interface lspt_rsp_if;
    import lspt_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] sample_count;
    logic [SUM_W-1:0] duration_total;
    logic [DUR_W-1:0] duration_peak;
    logic [DUR_W-1:0] quantile_value;
    logic             none_stored;

    modport source (output valid, sample_count, duration_total, duration_peak,
                    quantile_value, none_stored, input ready);
    modport sink   (input valid, sample_count, duration_total, duration_peak,
                    quantile_value, none_stored, output ready);
endinterface

>>> rtl/lspt_cell.sv
// one slot of the sorted insertion chain
module lspt_cell (
    input  logic                         clk,
    input  logic                         ins_en,
    input  logic                         valid,
    input  logic [lspt_pkg::DUR_W-1:0]   din,
    input  lspt_pkg::link_t              left,
    output lspt_pkg::link_t              link
);
    import lspt_pkg::*;

    logic [DUR_W-1:0] val_reg;
    logic [DUR_W-1:0] val_next;
    logic             gt;

    // empty slot counts as larger than anything
    assign gt = !valid || (val_reg > din);

    always_comb
    begin
        val_next = val_reg;
        if (ins_en && gt)
        begin
            val_next = left.gt ? left.val : din;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign link.val = val_reg;
    assign link.gt  = gt;

endmodule

>>> rtl/lspt_chain.sv
// row of cells kept in ascending order, fill count and rank read
module lspt_chain (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rec_en,
    input  logic [lspt_pkg::DUR_W-1:0]    din,
    input  logic [lspt_pkg::IDX_W-1:0]    rank,
    output logic [lspt_pkg::FILL_W-1:0]   fill,
    output logic [lspt_pkg::DUR_W-1:0]    rd_val
);
    import lspt_pkg::*;

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              ins_en;
    link_t             links [SAMPLE_DEPTH];
    link_t             head;

    assign ins_en = rec_en && (fill_reg < FILL_W'(SAMPLE_DEPTH));
    assign head   = '{val: '0, gt: 1'b0};

    genvar i;
    generate
        for (i = 0; i < SAMPLE_DEPTH; i++)
        begin : g_cell
            lspt_cell u_cell (
                .clk    (clk),
                .ins_en (ins_en),
                .valid  (FILL_W'(i) < fill_reg),
                .din    (din),
                .left   ((i == 0) ? head : links[(i == 0) ? 0 : i - 1]),
                .link   (links[i])
            );
        end
    endgenerate

    always_comb
    begin
        fill_next = fill_reg;
        if (ins_en)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    assign fill   = fill_reg;
    assign rd_val = links[rank].val;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(SAMPLE_DEPTH))
        else $error("fill count beyond depth");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        ins_en |=> fill_reg == $past(fill_reg) + FILL_W'(1))
        else $error("insert did not advance fill");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg >= FILL_W'(2) |-> links[0].val <= links[1].val)
        else $error("chain head out of order");

endmodule

>>> rtl/latency_sample_percentile_tracker.sv
// top level: saturating stats, sorted sample chain and percentile query control
//
//  channel   | dir | payload                                               | handshake
//  ----------+-----+-------------------------------------------------------+-------------
//  request   | in  | req_type, sample_duration, quantile_fraction          | valid/ready
//  response  | out | sample_count, duration_total, duration_peak,          | valid/ready
//            |     | quantile_value, none_stored                           |
//
// a record transaction inserts the sample in order into the cell chain and loads
// the response register at the accepting edge
// in a query transaction the rank multiply registers the rank, then the
// rank-indexed read of the chain loads the response register
// one transaction is in flight at a time; request ready is high in idle when the
// response register is empty or being taken in the same cycle
// async active-low reset clears count, sum, peak, fill and the handshake state;
// cell contents are not cleared since only filled slots are ever read
module latency_sample_percentile_tracker (
    input  logic       clk,
    input  logic       rst_n,
    lspt_req_if.sink   request,
    lspt_rsp_if.source response
);
    import lspt_pkg::*;

    state_t            state_reg,  state_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [SUM_W-1:0]  sum_reg,    sum_next;
    logic [DUR_W-1:0]  peak_reg,   peak_next;
    logic [IDX_W-1:0]  rank_reg,   rank_next;

    logic              rsp_valid_reg, rsp_valid_next;
    logic [CNT_W-1:0]  rsp_count_reg, rsp_count_next;
    logic [SUM_W-1:0]  rsp_sum_reg,   rsp_sum_next;
    logic [DUR_W-1:0]  rsp_peak_reg,  rsp_peak_next;
    logic [DUR_W-1:0]  rsp_qval_reg,  rsp_qval_next;
    logic              rsp_none_reg,  rsp_none_next;

    logic              in_ready;
    logic              in_fire;
    logic              rec_fire;
    logic              qry_fire;
    logic [FILL_W-1:0] fill;
    logic [DUR_W-1:0]  rd_val;
    logic [SUM_W:0]    sum_wide;
    logic [FRAC_W-1:0] frac_sat;
    logic [IDX_W-1:0]  n_m1;
    logic [FILL_W-1:0] fill_m1;
    logic [PROD_W-1:0] prod;

    // accept only when the response slot is free by the next edge
    assign in_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || response.ready);
    assign in_fire  = request.valid && in_ready;
    assign rec_fire = in_fire && (request.req_type == REQ_RECORD);
    assign qry_fire = in_fire && (request.req_type == REQ_QUERY);

    lspt_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .rec_en (rec_fire),
        .din    (request.sample_duration),
        .rank   (rank_reg),
        .fill   (fill),
        .rd_val (rd_val)
    );

    // rank = floor(p * (n - 1)), p clamped to 1.0 so the rank never passes n - 1
    assign frac_sat = (request.quantile_fraction > FRAC_ONE) ? FRAC_ONE
                                                             : request.quantile_fraction;
    assign fill_m1  = fill - FILL_W'(1);
    assign n_m1     = (fill == '0) ? '0 : fill_m1[IDX_W-1:0];
    assign prod     = PROD_W'(frac_sat) * PROD_W'(n_m1);
    assign rank_next = prod[FRAC_SHIFT +: IDX_W];

    // saturating stats
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(request.sample_duration);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        peak_next      = peak_reg;
        rsp_valid_next = rsp_valid_reg && !response.ready;
        rsp_count_next = rsp_count_reg;
        rsp_sum_next   = rsp_sum_reg;
        rsp_peak_next  = rsp_peak_reg;
        rsp_qval_next  = rsp_qval_reg;
        rsp_none_next  = rsp_none_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (rec_fire)
                begin
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    sum_next  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                    peak_next = (request.sample_duration > peak_reg)
                              ? request.sample_duration : peak_reg;
                    // record response carries the updated stats
                    rsp_valid_next = 1'b1;
                    rsp_count_next = count_next;
                    rsp_sum_next   = sum_next;
                    rsp_peak_next  = peak_next;
                    rsp_qval_next  = '0;
                    rsp_none_next  = 1'b0;
                end
                else if (qry_fire)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // response slot was freed when the query was taken
                rsp_valid_next = 1'b1;
                rsp_count_next = count_reg;
                rsp_sum_next   = sum_reg;
                rsp_peak_next  = peak_reg;
                rsp_none_next  = (fill == '0);
                rsp_qval_next  = (fill == '0) ? '0 : rd_val;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            peak_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            peak_reg      <= peak_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (qry_fire)
        begin
            rank_reg <= rank_next;
        end
        rsp_count_reg <= rsp_count_next;
        rsp_sum_reg   <= rsp_sum_next;
        rsp_peak_reg  <= rsp_peak_next;
        rsp_qval_reg  <= rsp_qval_next;
        rsp_none_reg  <= rsp_none_next;
    end

    assign request.ready           = in_ready;
    assign response.valid          = rsp_valid_reg;
    assign response.sample_count   = rsp_count_reg;
    assign response.duration_total = rsp_sum_reg;
    assign response.duration_peak  = rsp_peak_reg;
    assign response.quantile_value = rsp_qval_reg;
    assign response.none_stored    = rsp_none_reg;

    a_query_reads: assert property (@(posedge clk) disable iff (!rst_n)
        qry_fire |=> state_reg == ST_READ)
        else $error("query transaction did not enter read");

    a_record_result: assert property (@(posedge clk) disable iff (!rst_n)
        rec_fire |=> rsp_valid_reg && count_reg != '0 && !rsp_none_reg)
        else $error("record transaction gave no response");

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> !rsp_valid_reg)
        else $error("response slot busy during query read");

endmodule

>>> tb/tb_latency_sample_percentile_tracker.sv
// self-checking testbench for the latency sample percentile tracker
module tb_latency_sample_percentile_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    import lspt_pkg::*;

    // idle cycles with no transaction on either channel before the run is called hung
    localparam int WATCHDOG_LIMIT = 2000;
    // cycles to let pass after the last response before the final verdict
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 1400;

    localparam logic [SUM_W-1:0] TOTAL_MAX = '1;
    localparam logic [DUR_W-1:0] DUR_MAX   = '1;

    // one request transaction as the sender sees it
    typedef struct packed {
        logic              req_type;
        logic [DUR_W-1:0]  duration;
        logic [FRAC_W-1:0] fraction;
    } req_item_t;

    // one response transaction, field for field
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] total;
        logic [DUR_W-1:0] peak;
        logic [DUR_W-1:0] qval;
        logic             none;
    } stats_t;

    logic clk;
    logic rst_n;

    lspt_req_if req_ch ();
    lspt_rsp_if rsp_ch ();

    latency_sample_percentile_tracker DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch)
    );

    // stimulus backlog and the stats each accepted request should produce
    req_item_t req_backlog[$];
    stats_t    stats_due[$];

    int total_reqs    = 0;
    int accepted_reqs = 0;
    int checked_rsps  = 0;
    int error_count   = 0;

    // predictor state: counters and the stored samples kept in ascending order
    logic [CNT_W-1:0] count_acc;
    logic [SUM_W-1:0] total_acc;
    logic [DUR_W-1:0] peak_acc;
    logic [DUR_W-1:0] ordered_samples [SAMPLE_DEPTH];
    int               held;

    // coverage bookkeeping for the summary
    int record_seen = 0;
    int query_seen  = 0;
    int empty_seen  = 0;
    int full_drops  = 0;
    int sat_records = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor: updates the shadow state and returns the expected response
    // ------------------------------------------------------------------
    function automatic stats_t tally_request(req_item_t it);
        stats_t            r;
        logic [SUM_W:0]    wide;
        logic [63:0]       prod;
        logic [FRAC_W-1:0] frac;
        int                pos;
        int                rank;
        r = '0;
        if (it.req_type == REQ_RECORD)
        begin
            record_seen++;
            if (count_acc != '1)
                count_acc = count_acc + CNT_W'(1);
            // saturating add: any carry out of the 48-bit sum pins it at max
            wide = {1'b0, total_acc} + (SUM_W + 1)'(it.duration);
            if (wide[SUM_W])
            begin
                total_acc = TOTAL_MAX;
                sat_records++;
            end
            else
                total_acc = wide[SUM_W-1:0];
            if (it.duration > peak_acc)
                peak_acc = it.duration;
            // sorted insertion, equal values stay side by side
            if (held < SAMPLE_DEPTH)
            begin
                pos = held;
                while (pos > 0 && ordered_samples[pos-1] > it.duration)
                begin
                    ordered_samples[pos] = ordered_samples[pos-1];
                    pos--;
                end
                ordered_samples[pos] = it.duration;
                held++;
            end
            else
                full_drops++;
        end
        else
        begin
            query_seen++;
            if (held == 0)
            begin
                r.none = 1'b1;
                empty_seen++;
            end
            else
            begin
                // fractions above 1.0 clamp to 1.0, rank is floor(p * (n-1))
                frac = (it.fraction > FRAC_ONE) ? FRAC_ONE : it.fraction;
                prod = 64'(frac) * 64'(held - 1);
                rank = int'(prod >> FRAC_SHIFT);
                if (rank > held - 1)
                    rank = held - 1;
                r.qval = ordered_samples[rank];
            end
        end
        r.count = count_acc;
        r.total = total_acc;
        r.peak  = peak_acc;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [DUR_W-1:0] pick_duration();
        logic [DUR_W-1:0] d;
        case ($urandom_range(0, 3))
            0:       d = DUR_W'($urandom_range(0, 15));      // many duplicates
            1:       d = $urandom();
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       d = '0;
                    1:       d = DUR_MAX;
                    2:       d = 32'h8000_0000;
                    default: d = 32'h7FFF_FFFF;
                endcase
            end
            default: d = DUR_W'($urandom_range(0, 100000));
        endcase
        return d;
    endfunction

    function automatic logic [FRAC_W-1:0] pick_fraction();
        logic [FRAC_W-1:0] f;
        case ($urandom_range(0, 2))
            0:       f = FRAC_W'($urandom_range(0, 131071));
            1:       f = FRAC_W'($urandom_range(0, 65536));
            default:
            begin
                case ($urandom_range(0, 6))
                    0:       f = '0;
                    1:       f = FRAC_W'(1);
                    2:       f = FRAC_W'(32768);
                    3:       f = FRAC_W'(65535);
                    4:       f = FRAC_ONE;
                    5:       f = FRAC_W'(65537);
                    default: f = '1;
                endcase
            end
        endcase
        return f;
    endfunction

    task automatic queue_record(input logic [DUR_W-1:0] d);
        req_item_t it;
        it.req_type = REQ_RECORD;
        it.duration = d;
        it.fraction = pick_fraction();
        req_backlog.push_back(it);
        total_reqs++;
    endtask

    task automatic queue_query(input logic [FRAC_W-1:0] f);
        req_item_t it;
        it.req_type = REQ_QUERY;
        it.duration = $urandom();
        it.fraction = f;
        req_backlog.push_back(it);
        total_reqs++;
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of transactions separated by random gaps
    // ------------------------------------------------------------------
    req_item_t cur_item;
    int        burst_left = 1;
    int        gap_left   = 0;

    function automatic int pick_gap();
        int g;
        case ($urandom_range(0, 7))
            0, 1, 2: g = 0;                         // back to back bursts
            3, 4, 5: g = $urandom_range(1, 4);
            6:       g = $urandom_range(5, 10);
            default: g = $urandom_range(11, 20);
        endcase
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid             <= 1'b0;
            req_ch.req_type          <= REQ_RECORD;
            req_ch.sample_duration   <= '0;
            req_ch.quantile_fraction <= '0;
        end
        else
        begin
            // transaction taken at this edge: predict its response now
            if (req_ch.valid && req_ch.ready)
            begin
                stats_due.push_back(tally_request(cur_item));
                accepted_reqs++;
            end
            // drive the next item once the slot is free
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left > 0 || req_backlog.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    cur_item = req_backlog.pop_front();
                    req_ch.valid             <= 1'b1;
                    req_ch.req_type          <= cur_item.req_type;
                    req_ch.sample_duration   <= cur_item.duration;
                    req_ch.quantile_fraction <= cur_item.fraction;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = pick_gap();
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: response ready follows its own stall pattern
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int mode_left  = 0;
    int mode_phase = 0;
    int mode_period = 2;

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: mismatch on %s in response %0d: expected %0h, actual %0h",
                     $time, name, checked_rsps, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stats_t exp_s;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (stats_due.size() == 0)
                begin
                    $display("%0t: response with no request outstanding: %s %0h",
                             $time, "expected none, actual count", rsp_ch.sample_count);
                    error_count++;
                end
                else
                begin
                    exp_s = stats_due.pop_front();
                    check_field("sample_count", 64'(exp_s.count), 64'(rsp_ch.sample_count));
                    check_field("duration_total", 64'(exp_s.total), 64'(rsp_ch.duration_total));
                    check_field("duration_peak", 64'(exp_s.peak), 64'(rsp_ch.duration_peak));
                    check_field("quantile_value", 64'(exp_s.qval), 64'(rsp_ch.quantile_value));
                    check_field("none_stored", 64'(exp_s.none), 64'(rsp_ch.none_stored));
                end
                checked_rsps++;
            end
            // pick a new stall stretch when the current one runs out
            if (mode_left == 0)
            begin
                stall_mode  = $urandom_range(0, 3);
                mode_left   = (stall_mode == 3) ? $urandom_range(1, 25) : $urandom_range(1, 40);
                mode_period = $urandom_range(2, 5);
                mode_phase  = 0;
            end
            mode_left--;
            mode_phase++;
            case (stall_mode)
                0:       rsp_ch.ready <= 1'b1;                                // no stalls
                1:       rsp_ch.ready <= 1'($urandom_range(0, 1));          // coin flip
                2:       rsp_ch.ready <= (mode_phase % mode_period) == 0;  // periodic
                default: rsp_ch.ready <= 1'b0;                                // long stall
            endcase
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transaction means the block hung
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog: no transaction for %0d cycles, %0d outstanding",
                         $time, idle_cycles, stats_due.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus plan, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        clk   = 1'b0;
        rst_n = 1'b0;
        req_ch.valid             = 1'b0;
        req_ch.req_type          = REQ_RECORD;
        req_ch.sample_duration   = '0;
        req_ch.quantile_fraction = '0;
        rsp_ch.ready             = 1'b0;

        count_acc = '0;
        total_acc = '0;
        peak_acc  = '0;
        held      = 0;

        // directed: queries on an empty store at the fraction extremes
        queue_query('0);
        queue_query(FRAC_ONE);
        queue_query('1);
        // one zero sample, then the smallest and an over-range fraction
        queue_record('0);
        queue_query('0);
        queue_query('1);
        // largest duration, then just-below-one, exactly-one and just-above-one fractions
        queue_record(DUR_MAX);
        queue_query(FRAC_W'(65535));
        queue_query(FRAC_ONE);
        queue_query(FRAC_W'(65537));
        // duplicates so the rank must pick among equal values
        queue_record(32'd5);
        queue_record(32'd5);
        queue_record(32'd5);
        queue_record(32'd1);
        queue_query(FRAC_W'(32768));
        queue_query(FRAC_W'(1));
        queue_record(32'h8000_0000);
        queue_record(32'h7FFF_FFFF);
        queue_query(FRAC_W'(16384));
        queue_query(FRAC_W'(49152));
        queue_query(FRAC_W'(100000));
        queue_query(FRAC_W'(65536 - 8192));

        // random mix: the store fills part way through, then records are dropped
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 99) < 55)
                queue_record(pick_duration());
            else
                queue_query(pick_fraction());
        end

        // a tail of mixed traffic with the store already full
        for (i = 0; i < 40; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                queue_record(pick_duration());
            else
                queue_query(pick_fraction());
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_reqs < total_reqs || stats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (stats_due.size() != 0)
        begin
            $display("%0t: %0d responses never arrived", $time, stats_due.size());
            error_count++;
        end

        $display("summary: %0d requests (%0d records, %0d queries, %0d on an empty store)",
                 accepted_reqs, record_seen, query_seen, empty_seen);
        $display("summary: %0d responses checked, store held %0d, %0d dropped when full",
                 checked_rsps, held, full_drops);
        $display("summary: %0d records at saturated sum, %0d errors",
                 sat_records, error_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
rtl/lspt_pkg.sv
rtl/lspt_if.sv
rtl/lspt_cell.sv
rtl/lspt_chain.sv
rtl/latency_sample_percentile_tracker.sv
tb/tb_latency_sample_percentile_tracker.sv
